/* rtl/avdc_pkg.sv */
package avdc_pkg;

  // Field widths
  localparam int unsigned VoltW = 14;
  localparam int unsigned DegW  = 9;
  localparam int unsigned OffW  = 10;
  localparam int unsigned TimeW = 32;
  localparam int unsigned DirW  = 16;

  // Serial divider geometry: 39-bit dividend, 14-bit divisor, up to 25 quotient bits
  localparam int unsigned DivNumW  = 39;
  localparam int unsigned DivQW    = 25;
  localparam int unsigned DivStepW = 5;
  localparam logic [DivStepW-1:0] DivAngleSteps = 5'd25;
  localparam logic [DivStepW-1:0] DivRadSteps   = 5'd15;

  // Serial multiplier: 24-bit magnitude times 34-bit pi constant
  localparam int unsigned MagW     = 24;
  localparam int unsigned PiW      = 34;
  localparam int unsigned ProdW    = MagW + PiW;
  localparam int unsigned MulCntW  = 5;
  localparam logic [PiW-1:0] PiQ32 = 34'd13493037705;

  // Degrees to radians: divide by 1440 after dropping 32 fraction bits
  localparam logic [VoltW-1:0] RadDivisor = 14'd1440;
  localparam logic [25:0]      RadHalf    = 26'd720;

  // Angle in units of 2^-16 degree, 27-bit signed
  localparam int unsigned AngW = 27;
  localparam logic signed [AngW-1:0] FullTurn    = 27'sd23592960;
  localparam logic signed [AngW-1:0] HalfTurn    = 27'sd11796480;
  localparam logic signed [AngW-1:0] NegHalfTurn = -27'sd11796480;

  localparam logic [DegW-1:0]  ScaleMax       = 9'd360;
  localparam logic [TimeW-1:0] CalWindowMs    = 32'd30000;
  localparam logic [VoltW-1:0] CalSpreadMinMv = 14'd1000;

  // Configuration register indexes
  localparam logic [1:0] RegVoltMin   = 2'd0;
  localparam logic [1:0] RegVoltMax   = 2'd1;
  localparam logic [1:0] RegDeadzone  = 2'd2;
  localparam logic [1:0] RegBearing   = 2'd3;

  typedef enum logic [1:0] {
    CAL_EV_NONE = 2'd0,
    CAL_EV_DONE = 2'd1,
    CAL_EV_FAIL = 2'd2
  } cal_ev_e;

  typedef struct packed {
    logic [VoltW-1:0] voltage_mv;
    logic             pin_valid;
    logic             calibrate;
    logic [TimeW-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [DirW-1:0] direction;
    logic                   direction_valid;
    logic                   cal_running;
    cal_ev_e                cal_event;
    logic [VoltW-1:0]       cal_min_mv;
    logic [VoltW-1:0]       cal_max_mv;
  } out_item_t;

  // Request to the shared serial divider
  typedef struct packed {
    logic                start;
    logic [DivStepW-1:0] steps;
    logic [VoltW-1:0]    divisor;
    logic [DivNumW-1:0]  dividend;
  } div_req_t;

  // Calibration status after the latest beat
  typedef struct packed {
    logic             running;
    cal_ev_e          event_code;
    logic [VoltW-1:0] low_mv;
    logic [VoltW-1:0] high_mv;
  } cal_stat_t;

endpackage

/* rtl/avdc_div.sv */
module avdc_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  avdc_pkg::div_req_t    req_i,
  output logic                  done_o,
  output logic [avdc_pkg::DivQW-1:0] quot_o
);
  import avdc_pkg::*;

  logic [VoltW-1:0]    rem_q, rem_d;
  logic [DivQW-1:0]    low_q;
  logic [DivQW-1:0]    quot_q;
  logic [VoltW-1:0]    divisor_q;
  logic [DivStepW-1:0] cnt_q;
  logic                busy_q;
  logic                done_q;
  logic [VoltW:0]      trial;
  logic                qbit;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, low_q[DivQW-1]};
    qbit  = (trial >= {1'b0, divisor_q});
    if (qbit) begin
      rem_d = VoltW'(trial - {1'b0, divisor_q});
    end else begin
      rem_d = trial[VoltW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivStepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder, dividend tail and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= req_i.dividend[DivNumW-1:DivQW];
      low_q     <= req_i.dividend[DivQW-1:0];
      divisor_q <= req_i.divisor;
      quot_q    <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      low_q  <= {low_q[DivQW-2:0], 1'b0};
      quot_q <= {quot_q[DivQW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* rtl/avdc_smul.sv */
module avdc_smul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [avdc_pkg::MagW-1:0]   mag_i,
  output logic                        done_o,
  output logic [avdc_pkg::ProdW-1:0]  prod_o
);
  import avdc_pkg::*;

  logic [MagW-1:0]    mag_q;
  logic [ProdW-1:0]   acc_q;
  logic [MulCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= MulCntW'(MagW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == MulCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift-add, magnitude MSB first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= mag_i;
      acc_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[MagW-2:0], 1'b0};
      acc_q <= {acc_q[ProdW-2:0], 1'b0} + (mag_q[MagW-1] ? ProdW'(PiQ32) : '0);
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* rtl/avdc_cal.sv */
module avdc_cal (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic                         cal_i,
  input  logic [avdc_pkg::VoltW-1:0]   volt_i,
  input  logic [avdc_pkg::TimeW-1:0]   now_i,
  output avdc_pkg::cal_stat_t          stat_o
);
  import avdc_pkg::*;

  logic             active_q, active_d;
  logic [TimeW-1:0] start_q, start_d;
  logic [VoltW-1:0] low_q, low_d;
  logic [VoltW-1:0] high_q, high_d;
  cal_ev_e          event_q, event_d;
  logic [TimeW-1:0] win_start;
  logic [VoltW-1:0] low0, high0;
  logic [TimeW-1:0] elapsed;

  // One calibration step on the stored voltage
  always_comb begin
    active_d = active_q;
    start_d  = start_q;
    low_d    = low_q;
    high_d   = high_q;
    event_d  = CAL_EV_NONE;
    win_start = active_q ? start_q : now_i;
    low0      = active_q ? low_q : volt_i;
    high0     = active_q ? high_q : volt_i;
    elapsed   = now_i - win_start;
    if (cal_i) begin
      active_d = 1'b1;
      start_d  = win_start;
      high_d   = (volt_i > high0) ? volt_i : high0;
      low_d    = (volt_i < low0) ? volt_i : low0;
      if (elapsed > CalWindowMs) begin
        event_d  = ((high_d - low_d) >= CalSpreadMinMv) ? CAL_EV_DONE : CAL_EV_FAIL;
        active_d = 1'b0;
        start_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      start_q  <= '0;
      low_q    <= '0;
      high_q   <= '0;
      event_q  <= CAL_EV_NONE;
    end else if (step_i) begin
      active_q <= active_d;
      start_q  <= start_d;
      low_q    <= low_d;
      high_q   <= high_d;
      event_q  <= event_d;
    end
  end

  assign stat_o.running    = active_q;
  assign stat_o.event_code = event_q;
  assign stat_o.low_mv     = low_q;
  assign stat_o.high_mv    = high_q;

endmodule

/* rtl/analog_vane_direction_calibrate.sv */
// Sequence: a beat with pin_valid 0 goes from S_IDLE straight to S_DONE, which loads
//   the output register; with pin_valid 1 it runs the 25-step angle divide, up to 2
//   wrap corrections, the 24-step serial pi multiply and the 15-step radian divide,
//   with hand-off states before the divides, and then reaches S_DONE.
// Throughput: one beat at a time; the next beat is taken once the current one has
//   reached the output register, which waits while a result is held under stall.
// Reset: asynchronous, active low; config to 0, 3300, 0, 0, control state to zero.
module analog_vane_direction_calibrate (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  avdc_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output avdc_pkg::out_item_t   out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [avdc_pkg::VoltW-1:0] cfg_data_i
);
  import avdc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVA_GO,
    S_DIVA_WAIT,
    S_WRAP,
    S_MUL_WAIT,
    S_DIVB_GO,
    S_DIVB_WAIT,
    S_DONE
  } state_e;

  state_e state_q;

  logic [VoltW-1:0]        volt_min_q, volt_max_q;
  logic [DegW-1:0]         deadzone_q;
  logic signed [OffW-1:0]  offset_q;
  logic [VoltW-1:0]        last_volt_q;
  logic signed [DirW-1:0]  last_dir_q;

  logic [VoltW-1:0]        num_q, den_q;
  logic [DegW-1:0]         scale_q;
  logic signed [AngW-1:0]  ang_q;
  logic                    neg_q;
  logic                    pin_q;
  logic                    out_valid_q;
  out_item_t               out_q;

  logic                    accept;
  logic [VoltW-1:0]        v, lo, hi, num_d, den_d;
  logic [DegW-1:0]         scale_d;
  logic [VoltW-1:0]        stored_volt;
  logic [22:0]             num_scaled;
  logic [DivNumW-1:0]      angle_num;
  logic [DivNumW-1:0]      rad_num;
  logic [25:0]             rad_deg;
  div_req_t                div_req;
  logic                    div_done;
  logic [DivQW-1:0]        div_quot;
  logic signed [AngW-1:0]  ang_sum;
  logic signed [AngW-1:0]  ang_abs;
  logic                    mul_start;
  logic                    mul_done;
  logic [ProdW-1:0]        mul_prod;
  logic [DirW-1:0]         rad_mag;
  cal_stat_t               cal_stat;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_min_q <= '0;
      volt_max_q <= 14'd3300;
      deadzone_q <= '0;
      offset_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegVoltMin:  volt_min_q <= cfg_data_i;
        RegVoltMax:  volt_max_q <= cfg_data_i;
        RegDeadzone: deadzone_q <= cfg_data_i[DegW-1:0];
        RegBearing:  offset_q   <= $signed(cfg_data_i[OffW-1:0]);
        default:     ;
      endcase
    end
  end

  // Line through the calibration points, numerator clamped to 0..den
  always_comb begin
    v  = in_data_i.voltage_mv;
    lo = volt_min_q;
    hi = volt_max_q;
    if (hi > lo) begin
      den_d = hi - lo;
      if (v < lo)      num_d = '0;
      else if (v > hi) num_d = den_d;
      else             num_d = v - lo;
    end else if (hi < lo) begin
      den_d = lo - hi;
      if (v > lo)      num_d = '0;
      else if (v < hi) num_d = den_d;
      else             num_d = lo - v;
    end else begin
      den_d = VoltW'(1);
      num_d = (v > lo) ? VoltW'(1) : '0;
    end
    scale_d = ScaleMax - ((deadzone_q > ScaleMax) ? ScaleMax : deadzone_q);
  end

  assign stored_volt = in_data_i.pin_valid ? in_data_i.voltage_mv : last_volt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_volt_q <= '0;
    end else if (accept && in_data_i.pin_valid) begin
      last_volt_q <= in_data_i.voltage_mv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      num_q   <= num_d;
      den_q   <= den_d;
      scale_q <= scale_d;
    end
  end

  // Angle dividend: num*scale*65536 + den/2
  assign num_scaled = {9'b0, num_q} * {14'b0, scale_q};
  assign angle_num  = {num_scaled, 16'b0} + {26'b0, den_q[VoltW-1:1]};

  // Radian dividend: floor(mag*pi_q32 / 2^32) + 720, aligned for 15 quotient bits
  assign rad_deg = mul_prod[ProdW-1:32] + RadHalf;
  assign rad_num = {3'b0, rad_deg, 10'b0};

  always_comb begin
    div_req.start    = (state_q == S_DIVA_GO) || (state_q == S_DIVB_GO);
    if (state_q == S_DIVB_GO) begin
      div_req.steps    = DivRadSteps;
      div_req.divisor  = RadDivisor;
      div_req.dividend = rad_num;
    end else begin
      div_req.steps    = DivAngleSteps;
      div_req.divisor  = den_q;
      div_req.dividend = angle_num;
    end
  end

  avdc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Mapped angle plus bearing offset, in 2^-16 degree
  assign ang_sum   = $signed({2'b0, div_quot}) + $signed({offset_q[OffW-1], offset_q, 16'b0});
  assign ang_abs   = ang_q[AngW-1] ? -ang_q : ang_q;
  assign mul_start = (state_q == S_WRAP) && (ang_q <= HalfTurn) && (ang_q > NegHalfTurn);

  avdc_smul u_smul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mag_i   (ang_abs[MagW-1:0]),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign rad_mag = {1'b0, div_quot[DirW-2:0]};

  avdc_cal u_cal (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .cal_i  (in_data_i.calibrate),
    .volt_i (stored_volt),
    .now_i  (in_data_i.now_ms),
    .stat_o (cal_stat)
  );

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_dir_q  <= '0;
      out_valid_q <= 1'b0;
      pin_q       <= 1'b0;
      neg_q       <= 1'b0;
      ang_q       <= '0;
      out_q       <= '0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            pin_q   <= in_data_i.pin_valid;
            state_q <= in_data_i.pin_valid ? S_DIVA_GO : S_DONE;
          end
        end
        S_DIVA_GO: state_q <= S_DIVA_WAIT;
        S_DIVA_WAIT: begin
          if (div_done) begin
            ang_q   <= ang_sum;
            state_q <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (ang_q > HalfTurn) begin
            ang_q <= ang_q - FullTurn;
          end else if (ang_q <= NegHalfTurn) begin
            ang_q <= ang_q + FullTurn;
          end else begin
            neg_q   <= ang_q[AngW-1];
            state_q <= S_MUL_WAIT;
          end
        end
        S_MUL_WAIT: begin
          if (mul_done) begin
            state_q <= S_DIVB_GO;
          end
        end
        S_DIVB_GO: state_q <= S_DIVB_WAIT;
        S_DIVB_WAIT: begin
          if (div_done) begin
            last_dir_q <= neg_q ? $signed(-rad_mag) : $signed(rad_mag);
            state_q    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q           <= 1'b1;
            out_q.direction       <= last_dir_q;
            out_q.direction_valid <= pin_q;
            out_q.cal_running     <= cal_stat.running;
            out_q.cal_event       <= cal_stat.event_code;
            out_q.cal_min_mv      <= cal_stat.low_mv;
            out_q.cal_max_mv      <= cal_stat.high_mv;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* verif/tb_analog_vane_direction_calibrate.sv */
module tb_analog_vane_direction_calibrate;
  timeunit 1ns;
  timeprecision 1ps;

  import avdc_pkg::*;

  // Angle in 2^-16 degree units, pi in Q32, degree-to-radian divisor
  localparam longint FullTurnU16 = 64'd23592960;
  localparam longint HalfTurnU16 = 64'd11796480;
  localparam longint unsigned PiQ32Ref = 64'd13493037705;
  localparam longint unsigned RadDiv = 64'd1440 << 32;
  localparam int unsigned WindowMs = 30000;
  localparam int unsigned SpreadMinMv = 1000;
  localparam int unsigned RandomPerSetting = 200;
  localparam int unsigned LongHoldCycles = 300;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // Tracks vane state and calibration window, queues the readings it expects
  class vane_tracker;
    logic [VoltW-1:0]       volt_lo_cfg;
    logic [VoltW-1:0]       volt_hi_cfg;
    logic [DegW-1:0]        dz_cfg;
    logic signed [OffW-1:0] off_cfg;
    logic [VoltW-1:0]       held_mv;
    logic signed [DirW-1:0] held_dir;
    bit                     window_open;
    logic [TimeW-1:0]       window_t0;
    logic [VoltW-1:0]       window_lo;
    logic [VoltW-1:0]       window_hi;
    out_item_t              pending_readings[$];
    int                     mismatches;
    int                     samples_seen;
    int                     readings_checked;
    int                     windows_done;
    int                     windows_failed;

    function new();
      volt_lo_cfg = '0;
      volt_hi_cfg = 14'd3300;
      dz_cfg = '0;
      off_cfg = '0;
      held_mv = '0;
      held_dir = '0;
      window_open = 1'b0;
      window_t0 = '0;
      window_lo = '0;
      window_hi = '0;
      mismatches = 0;
      samples_seen = 0;
      readings_checked = 0;
      windows_done = 0;
      windows_failed = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [VoltW-1:0] val);
      case (idx)
        RegVoltMin: volt_lo_cfg = val;
        RegVoltMax: volt_hi_cfg = val;
        RegDeadzone: dz_cfg = val[DegW-1:0];
        RegBearing: off_cfg = val[OffW-1:0];
        default: ;
      endcase
    endfunction

    // Voltage -> clamped ratio -> degrees + offset -> wrapped -> Q2.13 radians
    function logic signed [DirW-1:0] angle_q13(logic [VoltW-1:0] v);
      longint lo, hi, vv, scale, n, d, a, t;
      longint unsigned mag, rad;
      logic signed [DirW-1:0] res;
      lo = volt_lo_cfg;
      hi = volt_hi_cfg;
      vv = v;
      scale = dz_cfg;
      if (scale > 360) scale = 360;
      scale = 360 - scale;
      if (hi > lo) begin
        d = hi - lo;
        n = vv - lo;
      end else if (hi < lo) begin
        d = lo - hi;
        n = lo - vv;
      end else begin
        d = 1;
        n = (vv > lo) ? 1 : 0;
      end
      if (n < 0) n = 0;
      if (n > d) n = d;
      a = (n * scale * 65536 + d / 2) / d;
      t = a + longint'(off_cfg) * 65536;
      t = t % FullTurnU16;
      if (t < 0) t = t + FullTurnU16;
      if (t > HalfTurnU16) t = t - FullTurnU16;
      mag = (t < 0) ? -t : t;
      rad = (mag * PiQ32Ref + RadDiv / 2) / RadDiv;
      res = rad[DirW-1:0];
      if (t < 0) res = -res;
      return res;
    endfunction

    function void log_sample(in_item_t s);
      cal_ev_e ev;
      logic [TimeW-1:0] elapsed;
      out_item_t r;
      ev = CAL_EV_NONE;
      samples_seen++;
      if (s.pin_valid) begin
        held_mv = s.voltage_mv;
        held_dir = angle_q13(s.voltage_mv);
      end
      // one calibration step on the stored voltage
      if (s.calibrate) begin
        if (!window_open) begin
          window_open = 1'b1;
          window_t0 = s.now_ms;
          window_lo = held_mv;
          window_hi = held_mv;
        end
        if (held_mv > window_hi) window_hi = held_mv;
        if (held_mv < window_lo) window_lo = held_mv;
        elapsed = s.now_ms - window_t0;
        if (elapsed > WindowMs) begin
          ev = (window_hi - window_lo >= SpreadMinMv) ? CAL_EV_DONE : CAL_EV_FAIL;
          if (ev == CAL_EV_DONE) windows_done++;
          else windows_failed++;
          window_open = 1'b0;
          window_t0 = '0;
        end
      end
      r.direction = held_dir;
      r.direction_valid = s.pin_valid;
      r.cal_running = window_open;
      r.cal_event = ev;
      r.cal_min_mv = window_lo;
      r.cal_max_mv = window_hi;
      pending_readings.push_back(r);
    endfunction

    function void check_reading(out_item_t got);
      out_item_t want;
      if (pending_readings.size() == 0) begin
        $error("reading with no sample pending: direction %0d", got.direction);
        mismatches++;
        return;
      end
      want = pending_readings.pop_front();
      readings_checked++;
      if (got.direction !== want.direction) begin
        $error("direction: expected %0d, got %0d", want.direction, got.direction);
        mismatches++;
      end
      if (got.direction_valid !== want.direction_valid) begin
        $error("direction_valid: expected %0d, got %0d", want.direction_valid,
               got.direction_valid);
        mismatches++;
      end
      if (got.cal_running !== want.cal_running) begin
        $error("cal_running: expected %0d, got %0d", want.cal_running, got.cal_running);
        mismatches++;
      end
      if (got.cal_event !== want.cal_event) begin
        $error("cal_event: expected %0d, got %0d", want.cal_event, got.cal_event);
        mismatches++;
      end
      if (got.cal_min_mv !== want.cal_min_mv) begin
        $error("cal_min_mv: expected %0d, got %0d", want.cal_min_mv, got.cal_min_mv);
        mismatches++;
      end
      if (got.cal_max_mv !== want.cal_max_mv) begin
        $error("cal_max_mv: expected %0d, got %0d", want.cal_max_mv, got.cal_max_mv);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_readings.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  in_item_t         in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  out_item_t        out_data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i;
  logic [VoltW-1:0] cfg_data_i;

  vane_tracker tracker = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_requests;
  int unsigned holds_served;
  int unsigned hold_left;
  int unsigned settings_used;

  // random sequence state
  logic [TimeW-1:0] clock_ms;
  int unsigned      burst_left;
  bit               burst_narrow;
  int unsigned      burst_center;

  analog_vane_direction_calibrate i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Result side: check accepted beats, then pick next stall value
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_reading(out_data_o);
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = LongHoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #30_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct <= 0;
        recv_stall_pct <= 0;
      end
      IDLE_SENDER: begin
        send_idle_pct <= 57;
        recv_stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct <= 0;
        recv_stall_pct <= 57;
      end
      default: begin
        send_idle_pct <= 12;
        recv_stall_pct <= 12;
      end
    endcase
  endtask

  task automatic send_sample(in_item_t s);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    tracker.log_sample(s);
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(8, 1) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic feed(int unsigned v, bit pv, bit cal, logic [TimeW-1:0] t);
    in_item_t s;
    s.voltage_mv = VoltW'(v);
    s.pin_valid = pv;
    s.calibrate = cal;
    s.now_ms = t;
    send_sample(s);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [VoltW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.write_reg(idx, val);
  endtask

  // Sender holds until every reading is back, then lets the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [VoltW-1:0] lo, logic [VoltW-1:0] hi,
                               logic [DegW-1:0] dz, logic signed [OffW-1:0] off);
    cfg_write(RegVoltMin, lo);
    cfg_write(RegVoltMax, hi);
    cfg_write(RegDeadzone, {{(VoltW-DegW){1'b0}}, dz});
    cfg_write(RegBearing, {{(VoltW-OffW){off[OffW-1]}}, off});
    settings_used++;
  endtask

  // Mostly a running clock with calibration bursts; some pure noise
  task automatic next_random(output in_item_t s);
    int unsigned pick;
    if ($urandom_range(99) < 12) begin
      s.voltage_mv = VoltW'($urandom_range(10000));
      s.pin_valid = 1'($urandom_range(1));
      s.calibrate = 1'($urandom_range(1));
      s.now_ms = $urandom();
    end else begin
      if (burst_left == 0 && $urandom_range(99) < 20) begin
        burst_left = $urandom_range(30, 4);
        burst_narrow = ($urandom_range(99) < 35);
        burst_center = $urandom_range(9400);
      end
      clock_ms = clock_ms + $urandom_range(8000);
      s.now_ms = clock_ms;
      s.pin_valid = ($urandom_range(99) < 90);
      pick = $urandom_range(9);
      if (burst_left > 0 && burst_narrow) begin
        s.voltage_mv = VoltW'(burst_center + $urandom_range(600));
      end else if (pick == 0) s.voltage_mv = tracker.volt_lo_cfg;
      else if (pick == 1) s.voltage_mv = tracker.volt_hi_cfg;
      else s.voltage_mv = VoltW'($urandom_range(10000));
      s.calibrate = (burst_left > 0) && ($urandom_range(99) < 92);
      if (burst_left > 0) burst_left--;
    end
  endtask

  initial begin
    in_item_t s;
    logic [VoltW-1:0] lo, hi;
    logic [DegW-1:0] dz;
    logic signed [OffW-1:0] off;
    idle_mode_e mode;

    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= RegVoltMin;
    cfg_data_i <= '0;
    hold_requests <= 0;
    holds_served = 0;
    hold_left = 0;
    settings_used = 0;
    burst_left = 0;
    burst_narrow = 1'b0;
    burst_center = 0;
    clock_ms = '0;
    set_idling(IDLE_NONE);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset calibration, range ends, invalid pin
    feed(0, 1, 0, 0);
    feed(3300, 1, 0, 10);
    feed(1650, 1, 0, 20);
    feed(10000, 1, 0, 30);
    feed(5000, 0, 0, 40);
    feed(8191, 1, 0, 50);
    // window: pause mid-way, boundary at exactly 30000 ms, then complete
    feed(500, 1, 1, 1000);
    feed(2000, 1, 1, 11000);
    feed(2500, 1, 0, 20000);
    feed(700, 0, 1, 31000);
    feed(900, 1, 1, 31001);
    // narrow spread fails; calibrating on a stale voltage
    feed(1000, 1, 1, 40000);
    feed(0, 0, 1, 50000);
    feed(1500, 1, 1, 70001);
    // window across the time wrap
    feed(4000, 1, 1, 32'hFFFF_F000);
    feed(4500, 1, 1, 32'h0000_7000);
    drain();

    // equal min and max
    apply_setting(14'd2000, 14'd2000, 9'd0, 10'sd90);
    feed(2000, 1, 0, 100);
    feed(2001, 1, 0, 200);
    drain();

    // min above max, oversized deadzone, offset of -360
    apply_setting(14'd3000, 14'd500, 9'd400, -10'sd360);
    feed(0, 1, 0, 300);
    feed(500, 1, 0, 400);
    feed(1750, 1, 0, 500);
    feed(3000, 1, 0, 600);
    feed(10000, 1, 0, 700);
    drain();

    apply_setting(14'd0, 14'd10000, 9'd359, 10'sd360);
    feed(10000, 1, 0, 800);
    feed(5000, 1, 0, 900);
    drain();

    // Random phases, each under its own register setting, cycling through the four idling patterns
    for (int p = 0; p < 8; p++) begin
      lo = VoltW'($urandom_range(10000));
      hi = VoltW'($urandom_range(10000));
      dz = ($urandom_range(9) == 0) ? DegW'($urandom_range(511, 360))
                                    : DegW'($urandom_range(359));
      off = OffW'($urandom_range(720) - 360);
      case (p)
        0: begin
          lo = 0;
          hi = 10000;
          dz = 0;
          off = 0;
        end
        1: begin
          lo = 10000;
          hi = 0;
          dz = 359;
          off = 360;
        end
        3: begin
          hi = lo;
          dz = 511;
          off = -360;
        end
        default: ;
      endcase
      case (p % 4)
        0: mode = IDLE_NONE;
        1: mode = IDLE_SENDER;
        2: mode = IDLE_RECEIVER;
        default: mode = IDLE_BOTH;
      endcase
      apply_setting(lo, hi, dz, off);
      set_idling(mode);
      clock_ms = $urandom();
      burst_left = 0;
      @(posedge clk_i);
      // receiver backs off while the sender keeps pushing
      if (p == 4) hold_requests <= hold_requests + 1;
      for (int k = 0; k < RandomPerSetting; k++) begin
        next_random(s);
        send_sample(s);
      end
      drain();
    end

    set_idling(IDLE_NONE);
    repeat (100) @(posedge clk_i);
    $display("Ran %0d samples under %0d register settings; %0d readings checked.",
             tracker.samples_seen, settings_used, tracker.readings_checked);
    $display("Calibration windows closed: %0d complete, %0d failed.",
             tracker.windows_done, tracker.windows_failed);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
